[design/hmbc_pkg.sv]
// ----------------------------------------------------------------------------
// hmbc_pkg - shared definitions for the heater mode and boost controller
// Event codes, reason codes, mode codes, register map and reset values.
// ----------------------------------------------------------------------------
package hmbc_pkg;

   localparam int unsigned TEMP_W = 10;
   localparam int unsigned TIME_W = 32;
   localparam int unsigned ADDR_W = 5;

   typedef logic [TEMP_W-1:0] temp_type;
   typedef logic [TIME_W-1:0] time_type;

   typedef enum logic [2:0] {
      ACT_SLEEP     = 3'd0,
      ACT_WAKE      = 3'd1,
      ACT_LOCK      = 3'd2,
      ACT_UNLOCK    = 3'd3,
      ACT_STEP_UP   = 3'd4,
      ACT_STEP_DOWN = 3'd5,
      ACT_TICK      = 3'd6
   } action_type;

   // sleep reasons
   localparam logic [1:0] SLEEP_MOTION = 2'd0;
   localparam logic [1:0] SLEEP_STAND  = 2'd1;
   // wake reasons
   localparam logic [1:0] WAKE_MOTION  = 2'd0;
   localparam logic [1:0] WAKE_BUTTONS = 2'd1;
   localparam logic [1:0] WAKE_STAND   = 2'd2;

   localparam logic [1:0] MODE_ACTIVE = 2'd0;
   localparam logic [1:0] MODE_ASLEEP = 2'd1;
   localparam logic [1:0] MODE_LOCKED = 2'd2;

   typedef enum logic [2:0] {
      REG_MIN_TARGET     = 3'd0,
      REG_SAFE_LIMIT     = 3'd1,
      REG_BOOST_LIMIT    = 3'd2,
      REG_BOOST_DURATION = 3'd3,
      REG_INITIAL_TARGET = 3'd4
   } reg_index_type;

   localparam temp_type STEP_DEG            = temp_type'(10);
   localparam temp_type RST_MIN_TARGET      = temp_type'(150);
   localparam temp_type RST_SAFE_LIMIT      = temp_type'(400);
   localparam temp_type RST_BOOST_LIMIT     = temp_type'(450);
   localparam time_type RST_BOOST_DURATION  = time_type'(60000);
   localparam temp_type RST_INITIAL_TARGET  = temp_type'(400);

endpackage

[design/heater_mode_and_boost_controller.sv]
// ----------------------------------------------------------------------------
// heater_mode_and_boost_controller - mode, setpoint and boost control
// Applies one event per transaction to the sleep/lock/boost state and
// returns the resulting mode, target and strobes.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake           | payload
//  req_     | in        | req_valid/req_ready | action reason element_present
//           |           |                     | measured_valid tip_temp now_ms
//  rsp_     | out       | rsp_valid/rsp_ready | mode target_temp heating_on
//           |           |                     | boost_flag save_value save_strobe
//           |           |                     | target_strobe
//  csr_     | in/out    | APB, pready high    | 5 registers at 4*i
//
// A transaction is captured in an input register, then combinational state
// update logic writes the result register; one event per cycle sustained
// while rsp_ready is high. Both stages hold when rsp_ready is low and the
// result stage is full; req_ready drops only when both stages are full.
// Reset is synchronous: config to defaults, target to the initial target.
// ----------------------------------------------------------------------------
module heater_mode_and_boost_controller (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [2:0]                req_action,
   input  logic [1:0]                req_reason,
   input  logic                      req_element_present,
   input  logic                      req_measured_valid,
   input  hmbc_pkg::temp_type        req_tip_temp,
   input  hmbc_pkg::time_type        req_now_ms,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [1:0]                rsp_mode,
   output hmbc_pkg::temp_type        rsp_target_temp,
   output logic                      rsp_heating_on,
   output logic                      rsp_boost_flag,
   output hmbc_pkg::temp_type        rsp_save_value,
   output logic                      rsp_save_strobe,
   output logic                      rsp_target_strobe,
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [hmbc_pkg::ADDR_W-1:0] paddr,
   input  logic [31:0]               pwdata,
   output logic [31:0]               prdata,
   output logic                      pready
);
   import hmbc_pkg::*;

   // configuration
   temp_type min_target_ff, safe_limit_ff, boost_limit_ff, initial_target_ff;
   time_type boost_duration_ff;

   // controller state
   logic     asleep_motion_ff, asleep_stand_ff, locked_ff, heater_enabled_ff;
   logic     boost_pending_ff, boost_running_ff;
   temp_type target_ff;
   time_type boost_start_ff;

   logic     asleep_motion_in, asleep_stand_in, locked_in, heater_enabled_in;
   logic     boost_pending_in, boost_running_in;
   temp_type target_in;
   time_type boost_start_in;

   // input stage
   logic       s1_valid_ff;
   logic [2:0] s1_action_ff;
   logic [1:0] s1_reason_ff;
   logic       s1_present_ff, s1_meas_valid_ff;
   temp_type   s1_meas_ff;
   time_type   s1_now_ff;

   // result stage
   logic       rsp_valid_ff;
   logic [1:0] mode_ff, mode_in;
   temp_type   save_value_ff, save_value_in;
   logic       save_strobe_ff, save_strobe_in;
   logic       target_strobe_ff, target_strobe_in;

   logic     advance, fire, cfg_write;
   logic     start_boost, run_now, boost_expired;
   logic [TEMP_W:0] step_up_sum;
   temp_type step_tmp, target_tmp;
   time_type start_eff, elapsed;

   assign pready    = 1'b1;
   assign cfg_write = psel & penable & pwrite;
   assign advance   = ~rsp_valid_ff | rsp_ready;
   assign fire      = s1_valid_ff & advance;
   assign req_ready = ~s1_valid_ff | advance;

   always_comb begin
      case (paddr[4:2])
         REG_MIN_TARGET:     prdata = {{(32-TEMP_W){1'b0}}, min_target_ff};
         REG_SAFE_LIMIT:     prdata = {{(32-TEMP_W){1'b0}}, safe_limit_ff};
         REG_BOOST_LIMIT:    prdata = {{(32-TEMP_W){1'b0}}, boost_limit_ff};
         REG_BOOST_DURATION: prdata = boost_duration_ff;
         REG_INITIAL_TARGET: prdata = {{(32-TEMP_W){1'b0}}, initial_target_ff};
         default:            prdata = '0;
      endcase
   end

   // event update
   always_comb begin
      asleep_motion_in  = asleep_motion_ff;
      asleep_stand_in   = asleep_stand_ff;
      locked_in         = locked_ff;
      heater_enabled_in = heater_enabled_ff;
      boost_pending_in  = boost_pending_ff;
      boost_running_in  = boost_running_ff;
      target_in         = target_ff;
      boost_start_in    = boost_start_ff;
      save_strobe_in    = 1'b0;
      target_strobe_in  = 1'b0;

      step_up_sum   = {1'b0, target_ff} + {1'b0, STEP_DEG};
      step_tmp      = '0;
      target_tmp    = target_ff;
      start_boost   = boost_pending_ff & ~boost_running_ff & s1_meas_valid_ff
                      & (s1_meas_ff > safe_limit_ff);
      run_now       = boost_running_ff | start_boost;
      start_eff     = start_boost ? s1_now_ff : boost_start_ff;
      elapsed       = s1_now_ff - start_eff;
      boost_expired = run_now & (elapsed >= boost_duration_ff);

      case (s1_action_ff)
         ACT_SLEEP: begin
            heater_enabled_in = 1'b0;
            if (s1_reason_ff == SLEEP_MOTION) asleep_motion_in = 1'b1;
            else if (s1_reason_ff == SLEEP_STAND) asleep_stand_in = 1'b1;
            boost_pending_in = 1'b0;
            boost_running_in = 1'b0;
            if (target_ff > safe_limit_ff) target_in = safe_limit_ff;
         end
         ACT_WAKE, ACT_UNLOCK: begin
            if (s1_action_ff == ACT_WAKE) begin
               if (s1_reason_ff == WAKE_MOTION || s1_reason_ff == WAKE_BUTTONS)
                  asleep_motion_in = 1'b0;
               else if (s1_reason_ff == WAKE_STAND)
                  asleep_stand_in = 1'b0;
            end else begin
               locked_in = 1'b0;
            end
            if (~locked_in & ~asleep_motion_in & ~asleep_stand_in) begin
               target_strobe_in  = 1'b1;
               heater_enabled_in = 1'b1;
            end
         end
         ACT_LOCK: begin
            heater_enabled_in = 1'b0;
            locked_in         = 1'b1;
            boost_pending_in  = 1'b0;
            boost_running_in  = 1'b0;
            if (target_ff > safe_limit_ff) target_in = safe_limit_ff;
         end
         ACT_STEP_UP: begin
            // boost_limit fits in 10 bits, so it also caps the overflow
            if (step_up_sum > {1'b0, boost_limit_ff}) step_tmp = boost_limit_ff;
            else step_tmp = step_up_sum[TEMP_W-1:0];
            target_in = step_tmp;
            if (step_tmp > safe_limit_ff) boost_pending_in = 1'b1;
            save_strobe_in   = 1'b1;
            target_strobe_in = 1'b1;
         end
         ACT_STEP_DOWN: begin
            step_tmp = (target_ff >= STEP_DEG) ? target_ff - STEP_DEG : '0;
            if (step_tmp < min_target_ff) step_tmp = min_target_ff;
            target_in = step_tmp;
            if (step_tmp > safe_limit_ff) begin
               boost_pending_in = 1'b1;
            end else begin
               boost_pending_in = 1'b0;
               boost_running_in = 1'b0;
            end
            save_strobe_in   = 1'b1;
            target_strobe_in = 1'b1;
         end
         ACT_TICK: begin
            if (~s1_present_ff) begin
               heater_enabled_in = 1'b0;
               locked_in         = 1'b1;
            end
            if (start_boost) begin
               boost_pending_in = 1'b0;
               boost_running_in = 1'b1;
               boost_start_in   = s1_now_ff;
            end
            if (boost_expired) begin
               if (target_ff > safe_limit_ff) begin
                  target_tmp       = safe_limit_ff;
                  target_strobe_in = 1'b1;
               end
               target_in        = target_tmp;
               boost_running_in = 1'b0;
            end
         end
         default: begin
         end
      endcase

      if (locked_in) mode_in = MODE_LOCKED;
      else if (asleep_motion_in | asleep_stand_in) mode_in = MODE_ASLEEP;
      else mode_in = MODE_ACTIVE;
      save_value_in = (target_in > safe_limit_ff) ? safe_limit_ff : target_in;
   end

   // control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         min_target_ff     <= RST_MIN_TARGET;
         safe_limit_ff     <= RST_SAFE_LIMIT;
         boost_limit_ff    <= RST_BOOST_LIMIT;
         boost_duration_ff <= RST_BOOST_DURATION;
         initial_target_ff <= RST_INITIAL_TARGET;
         asleep_motion_ff  <= 1'b0;
         asleep_stand_ff   <= 1'b0;
         locked_ff         <= 1'b0;
         heater_enabled_ff <= 1'b0;
         boost_pending_ff  <= 1'b0;
         boost_running_ff  <= 1'b0;
         target_ff         <= RST_INITIAL_TARGET;
         boost_start_ff    <= '0;
         s1_valid_ff       <= 1'b0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         if (req_ready) s1_valid_ff <= req_valid;
         if (advance) rsp_valid_ff <= s1_valid_ff;
         if (fire) begin
            asleep_motion_ff  <= asleep_motion_in;
            asleep_stand_ff   <= asleep_stand_in;
            locked_ff         <= locked_in;
            heater_enabled_ff <= heater_enabled_in;
            boost_pending_ff  <= boost_pending_in;
            boost_running_ff  <= boost_running_in;
            target_ff         <= target_in;
            boost_start_ff    <= boost_start_in;
         end
         if (cfg_write) begin
            case (paddr[4:2])
               REG_MIN_TARGET:     min_target_ff     <= pwdata[TEMP_W-1:0];
               REG_SAFE_LIMIT:     safe_limit_ff     <= pwdata[TEMP_W-1:0];
               REG_BOOST_LIMIT:    boost_limit_ff    <= pwdata[TEMP_W-1:0];
               REG_BOOST_DURATION: boost_duration_ff <= pwdata;
               REG_INITIAL_TARGET: begin
                  initial_target_ff <= pwdata[TEMP_W-1:0];
                  target_ff         <= pwdata[TEMP_W-1:0];
               end
               default: begin
               end
            endcase
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_valid & req_ready) begin
         s1_action_ff     <= req_action;
         s1_reason_ff     <= req_reason;
         s1_present_ff    <= req_element_present;
         s1_meas_valid_ff <= req_measured_valid;
         s1_meas_ff       <= req_tip_temp;
         s1_now_ff        <= req_now_ms;
      end
      if (fire) begin
         mode_ff          <= mode_in;
         save_value_ff    <= save_value_in;
         save_strobe_ff   <= save_strobe_in;
         target_strobe_ff <= target_strobe_in;
      end
   end

   // target, heater and boost outputs follow the state registers directly
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_mode          = mode_ff;
   assign rsp_target_temp   = target_ff;
   assign rsp_heating_on    = heater_enabled_ff;
   assign rsp_boost_flag    = boost_pending_ff | boost_running_ff;
   assign rsp_save_value    = save_value_ff;
   assign rsp_save_strobe   = save_strobe_ff;
   assign rsp_target_strobe = target_strobe_ff;

endmodule
